/* hdl/spq_pkg.sv */
// Shared constants, types and command/status structs for the sorted priority queue.
// No dependencies; every other file in hdl imports this package.
package spq_pkg;

    localparam int DEPTH         = 256;
    localparam int KEY_WIDTH     = 32;
    localparam int PAYLOAD_WIDTH = 32;
    localparam int ADDR_W        = $clog2(DEPTH);
    localparam int CNT_W         = $clog2(DEPTH + 1);

    localparam logic ACT_ENQ = 1'b0;
    localparam logic ACT_DEQ = 1'b1;

    typedef logic [2:0] t_res;
    localparam t_res RES_NONE      = 3'd0;
    localparam t_res RES_ECHO_OK   = 3'd1;
    localparam t_res RES_ECHO_FAIL = 3'd2;
    localparam t_res RES_DEQ_OK    = 3'd3;
    localparam t_res RES_DEQ_FAIL  = 3'd4;

    typedef struct packed {
        logic [KEY_WIDTH-1:0]     key;
        logic [PAYLOAD_WIDTH-1:0] payload;
    } t_entry;

    typedef struct packed {
        logic latch;     // capture the incoming word
        logic rd_head;   // read logical slot 0
        logic rd_prev;   // read logical slot pos-1
        logic rd_prev2;  // read logical slot pos-2
        logic wr_shift;  // move read entry down to slot pos, pos--
        logic wr_new;    // write new entry at slot pos, count++
        logic pop;       // advance head, count--
        t_res res;       // result to load into the output register
    } t_cmd;

    typedef struct packed {
        logic is_enq;
        logic full;
        logic empty;
        logic pos_one;
        logic key_less;
        logic out_free;
    } t_status;

endpackage

/* hdl/spq_ctrl.sv */
// Controller state machine for the sorted priority queue.
// Depends on spq_pkg; drives commands into spq_datapath and reads its status.
module spq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  spq_pkg::t_status i_status,
    output spq_pkg::t_cmd    o_cmd
);
    import spq_pkg::*;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DISPATCH = 3'd1;
    localparam logic [2:0] ST_DEQ_WAIT = 3'd2;
    localparam logic [2:0] ST_ENQ_CMP  = 3'd3;
    localparam logic [2:0] ST_ENQ_FIN  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_ready = (r_state == ST_IDLE) && i_status.out_free;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.res = RES_NONE;
        case (r_state)
            ST_IDLE: begin
                if (i_valid && o_ready) begin
                    o_cmd.latch = 1'b1;
                    n_state     = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (i_status.is_enq) begin
                    if (i_status.full) begin
                        o_cmd.res = RES_ECHO_FAIL;
                        n_state   = ST_IDLE;
                    end else if (i_status.empty) begin
                        o_cmd.wr_new = 1'b1;
                        o_cmd.res    = RES_ECHO_OK;
                        n_state      = ST_IDLE;
                    end else begin
                        o_cmd.rd_prev = 1'b1;
                        n_state       = ST_ENQ_CMP;
                    end
                end else begin
                    if (i_status.empty) begin
                        o_cmd.res = RES_DEQ_FAIL;
                        n_state   = ST_IDLE;
                    end else begin
                        o_cmd.rd_head = 1'b1;
                        n_state       = ST_DEQ_WAIT;
                    end
                end
            end
            ST_DEQ_WAIT: begin
                o_cmd.res = RES_DEQ_OK;
                o_cmd.pop = 1'b1;
                n_state   = ST_IDLE;
            end
            ST_ENQ_CMP: begin
                // smaller key ahead of the slot: shift it down and look further up
                if (i_status.key_less) begin
                    o_cmd.wr_shift = 1'b1;
                    if (i_status.pos_one) begin
                        n_state = ST_ENQ_FIN;
                    end else begin
                        o_cmd.rd_prev2 = 1'b1;
                    end
                end else begin
                    o_cmd.wr_new = 1'b1;
                    o_cmd.res    = RES_ECHO_OK;
                    n_state      = ST_IDLE;
                end
            end
            ST_ENQ_FIN: begin
                o_cmd.wr_new = 1'b1;
                o_cmd.res    = RES_ECHO_OK;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* hdl/spq_datapath.sv */
// Datapath for the sorted priority queue: circular entry memory, head/count/pos
// registers and the output register. Depends on spq_pkg; commanded by spq_ctrl.
module spq_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  spq_pkg::t_cmd                       i_cmd,
    output spq_pkg::t_status                    o_status,
    input  logic                                i_action,
    input  logic [spq_pkg::KEY_WIDTH-1:0]       i_key,
    input  logic [spq_pkg::PAYLOAD_WIDTH-1:0]   i_payload,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_success,
    output logic [spq_pkg::KEY_WIDTH-1:0]       o_out_key,
    output logic [spq_pkg::PAYLOAD_WIDTH-1:0]   o_out_payload
);
    import spq_pkg::*;

    // entries are kept sorted starting at r_head, wrapping round the memory
    t_entry mem [DEPTH];

    logic [ADDR_W-1:0]        r_head;
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         r_pos;
    logic                     r_action;
    logic [KEY_WIDTH-1:0]     r_key;
    logic [PAYLOAD_WIDTH-1:0] r_payload;
    t_entry                   r_rd;
    logic                     r_out_valid;
    logic                     r_success;
    logic [KEY_WIDTH-1:0]     r_out_key;
    logic [PAYLOAD_WIDTH-1:0] r_out_payload;

    logic [CNT_W-1:0]  pos_m1;
    logic [CNT_W-1:0]  pos_m2;
    logic [ADDR_W-1:0] rd_logical;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic              wr_en;
    t_entry            wr_data;

    function automatic logic [ADDR_W-1:0] phys(input logic [ADDR_W-1:0] head,
                                               input logic [ADDR_W-1:0] logical);
        logic [ADDR_W:0] sum;
        sum = {1'b0, head} + {1'b0, logical};
        if (sum >= (ADDR_W+1)'(DEPTH)) begin
            sum = sum - (ADDR_W+1)'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

    assign pos_m1 = r_pos - CNT_W'(1);
    assign pos_m2 = r_pos - CNT_W'(2);

    always_comb begin
        if (i_cmd.rd_prev) begin
            rd_logical = pos_m1[ADDR_W-1:0];
        end else if (i_cmd.rd_prev2) begin
            rd_logical = pos_m2[ADDR_W-1:0];
        end else begin
            rd_logical = '0;
        end
    end

    assign rd_en   = i_cmd.rd_head || i_cmd.rd_prev || i_cmd.rd_prev2;
    assign rd_addr = phys(r_head, rd_logical);
    assign wr_en   = i_cmd.wr_shift || i_cmd.wr_new;
    assign wr_addr = phys(r_head, r_pos[ADDR_W-1:0]);

    always_comb begin
        if (i_cmd.wr_shift) begin
            wr_data = r_rd;
        end else begin
            wr_data.key     = r_key;
            wr_data.payload = r_payload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= mem[rd_addr];
        end
    end

    // captured word; the insertion pointer is kept with head and count below
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_action  <= i_action;
            r_key     <= i_key;
            r_payload <= i_payload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_pos   <= '0;
        end else begin
            if (i_cmd.latch) begin
                r_pos <= r_count;
            end else if (i_cmd.wr_shift) begin
                r_pos <= pos_m1;
            end
            if (i_cmd.wr_new) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.pop) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (i_cmd.pop) begin
                if (r_head == ADDR_W'(DEPTH - 1)) begin
                    r_head <= '0;
                end else begin
                    r_head <= r_head + ADDR_W'(1);
                end
            end
        end
    end

    // output register: load a result, otherwise drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.res != RES_NONE) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.res)
            RES_ECHO_OK, RES_ECHO_FAIL: begin
                r_success     <= (i_cmd.res == RES_ECHO_OK);
                r_out_key     <= r_key;
                r_out_payload <= r_payload;
            end
            RES_DEQ_OK: begin
                r_success     <= 1'b1;
                r_out_key     <= r_rd.key;
                r_out_payload <= r_rd.payload;
            end
            RES_DEQ_FAIL: begin
                r_success     <= 1'b0;
                r_out_key     <= '0;
                r_out_payload <= '0;
            end
            default: begin
            end
        endcase
    end

    assign o_status.is_enq   = (r_action == ACT_ENQ);
    assign o_status.full     = (r_count == CNT_W'(DEPTH));
    assign o_status.empty    = (r_count == '0);
    assign o_status.pos_one  = (r_pos == CNT_W'(1));
    assign o_status.key_less = (r_rd.key < r_key);
    assign o_status.out_free = !r_out_valid || i_ready;

    assign o_valid       = r_out_valid;
    assign o_success     = r_success;
    assign o_out_key     = r_out_key;
    assign o_out_payload = r_out_payload;

endmodule

/* hdl/sorted_priority_queue.sv */
// Sorted priority queue, largest key first; one word in, one result word out.
// Accept to o_valid: a failed op or enqueue into an empty queue passes dispatch only; a
// dequeue dispatch and a head read; an enqueue dispatch, one shift per cycle of each
// smaller entry (bound by the memory's single write port), then the write. Next word
// taken the cycle after a result loads if the output is free. Synchronous active-low
// reset empties the queue at once. Depends on spq_pkg, spq_ctrl and spq_datapath.
module sorted_priority_queue (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_action,
    input  logic [spq_pkg::KEY_WIDTH-1:0]       i_key,
    input  logic [spq_pkg::PAYLOAD_WIDTH-1:0]   i_payload,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_success,
    output logic [spq_pkg::KEY_WIDTH-1:0]       o_out_key,
    output logic [spq_pkg::PAYLOAD_WIDTH-1:0]   o_out_payload
);
    import spq_pkg::*;

    t_cmd    cmd;
    t_status status;

    spq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    spq_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_action      (i_action),
        .i_key         (i_key),
        .i_payload     (i_payload),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_success     (o_success),
        .o_out_key     (o_out_key),
        .o_out_payload (o_out_payload)
    );

endmodule

/* hdl/spq_checker.sv */
// Port-level checks for sorted_priority_queue, attached by bind.
// Depends on spq_pkg for field widths.
module spq_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_valid,
    input logic                                o_ready,
    input logic                                i_action,
    input logic [spq_pkg::KEY_WIDTH-1:0]       i_key,
    input logic [spq_pkg::PAYLOAD_WIDTH-1:0]   i_payload,
    input logic                                o_valid,
    input logic                                i_ready,
    input logic                                o_success,
    input logic [spq_pkg::KEY_WIDTH-1:0]       o_out_key,
    input logic [spq_pkg::PAYLOAD_WIDTH-1:0]   o_out_payload
);
    import spq_pkg::*;

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result pending after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_success) && $stable(o_out_key)
                                && $stable(o_out_payload))
        else $error("stalled result changed");

    // one word at a time: no second accept right after one
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready && !o_valid)
        else $error("accept not followed by busy with empty output");

    // input only taken when the output register can free up
    a_ready_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_valid || i_ready)
        else $error("ready while output blocked");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);
